/* rtl/eap_pkg.sv */
`default_nettype none
package eap_pkg;

   localparam int TIME_BITS = 32;
   localparam int FRAC_BITS = 16;
   localparam int PROG_BITS = FRAC_BITS + 1;

   localparam logic [PROG_BITS-1:0] ONE_Q  = PROG_BITS'(1) << FRAC_BITS;
   localparam logic [PROG_BITS-1:0] HALF_Q = PROG_BITS'(1) << (FRAC_BITS - 1);

   localparam logic [1:0] PH_WAIT = 2'd0;
   localparam logic [1:0] PH_RUN  = 2'd1;
   localparam logic [1:0] PH_HELD = 2'd2;
   localparam logic [1:0] PH_ZERO = 2'd3;

   localparam logic [2:0] KIND_APPEAR = 3'd1;
   localparam logic [2:0] KIND_CUBIC  = 3'd2;
   localparam logic [2:0] KIND_BOUNCE = 3'd3;

   localparam logic [1:0] CSR_START_DELAY   = 2'd0;
   localparam logic [1:0] CSR_CYCLE_LENGTH  = 2'd1;
   localparam logic [1:0] CSR_REPEAT_ENABLE = 2'd2;
   localparam logic [1:0] CSR_EASE_KIND     = 2'd3;

   typedef struct packed {
      logic       valid;
      logic [1:0] phase;
   } tag_type;

endpackage
`default_nettype wire

/* rtl/eap_divider.sv */
`default_nettype none
// Pipelined remainder (one bit a stage) followed by a pipelined fraction divider.
module eap_divider (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          adv,
   input  wire eap_pkg::tag_type              tag_i,
   input  wire logic [eap_pkg::TIME_BITS-1:0] local_i,
   input  wire logic [eap_pkg::TIME_BITS-1:0] dur_i,
   output eap_pkg::tag_type                   tag_o,
   output logic      [eap_pkg::FRAC_BITS-1:0] frac_o
);
   localparam int TB = eap_pkg::TIME_BITS;
   localparam int FB = eap_pkg::FRAC_BITS;

   eap_pkg::tag_type rtag_ff [TB];
   logic [TB-1:0]    rem_ff  [TB];
   logic [TB-1:0]    num_ff  [TB];

   eap_pkg::tag_type ftag_ff [FB];
   logic [TB-1:0]    fr_ff   [FB];
   logic [FB-1:0]    fq_ff   [FB];

   for (genvar k = 0; k < TB; k++) begin : g_rem
      eap_pkg::tag_type tag_src;
      logic [TB-1:0]    rem_src;
      logic [TB-1:0]    num_src;
      logic [TB:0]      trial;
      logic [TB-1:0]    rem_in;
      logic [TB-1:0]    num_in;

      if (k == 0) begin : g_first
         assign tag_src = tag_i;
         assign rem_src = '0;
         assign num_src = local_i;
      end else begin : g_next
         assign tag_src = rtag_ff[k-1];
         assign rem_src = rem_ff[k-1];
         assign num_src = num_ff[k-1];
      end

      always_comb begin
         trial = {rem_src, num_src[TB-1]};
         if (trial >= {1'b0, dur_i}) begin
            trial = trial - {1'b0, dur_i};
         end
         rem_in = trial[TB-1:0];
         num_in = {num_src[TB-2:0], 1'b0};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            rtag_ff[k] <= '0;
         end else if (adv) begin
            rtag_ff[k] <= tag_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k] <= rem_in;
            num_ff[k] <= num_in;
         end
      end
   end

   // remainder r < d here, so 2r fits one extra bit
   for (genvar j = 0; j < FB; j++) begin : g_frac
      eap_pkg::tag_type tag_src;
      logic [TB-1:0]    r_src;
      logic [FB-1:0]    q_src;
      logic [TB:0]      dbl;
      logic [TB-1:0]    r_in;
      logic [FB-1:0]    q_in;

      if (j == 0) begin : g_first
         assign tag_src = rtag_ff[TB-1];
         assign r_src   = rem_ff[TB-1];
         assign q_src   = '0;
      end else begin : g_next
         assign tag_src = ftag_ff[j-1];
         assign r_src   = fr_ff[j-1];
         assign q_src   = fq_ff[j-1];
      end

      always_comb begin
         dbl = {r_src, 1'b0};
         if (dbl >= {1'b0, dur_i}) begin
            dbl  = dbl - {1'b0, dur_i};
            q_in = {q_src[FB-2:0], 1'b1};
         end else begin
            q_in = {q_src[FB-2:0], 1'b0};
         end
         r_in = dbl[TB-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ftag_ff[j] <= '0;
         end else if (adv) begin
            ftag_ff[j] <= tag_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            fr_ff[j] <= r_in;
            fq_ff[j] <= q_in;
         end
      end
   end

   assign tag_o  = ftag_ff[FB-1];
   assign frac_o = fq_ff[FB-1];

endmodule
`default_nettype wire

/* rtl/eap_ease.sv */
`default_nettype none
// Three-stage ease curve: setup, first square, second product and select.
module eap_ease (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          adv,
   input  wire logic [2:0]                    kind_i,
   input  wire eap_pkg::tag_type              tag_i,
   input  wire logic [eap_pkg::FRAC_BITS-1:0] frac_i,
   output eap_pkg::tag_type                   tag_o,
   output logic      [eap_pkg::PROG_BITS-1:0] prog_o
);
   localparam int FB = eap_pkg::FRAC_BITS;
   localparam int PB = eap_pkg::PROG_BITS;
   localparam logic [FB+1:0] ONE_X = (FB+2)'(1) << FB;
   localparam logic [FB+1:0] TWO_X = (FB+2)'(2) << FB;

   // stage A
   eap_pkg::tag_type taga_ff;
   logic [FB-1:0]    pa_ff;
   logic [PB-1:0]    qa_ff;
   logic [FB-1:0]    ya_ff;
   logic [1:0]       sega_ff;
   logic [FB+1:0]    x3;
   logic [FB+1:0]    xy;
   logic [1:0]       seg_in;

   always_comb begin
      x3 = {2'b00, frac_i} + {1'b0, frac_i, 1'b0};
      if (x3 < ONE_X) begin
         seg_in = 2'd0;
         xy     = x3;
      end else if (x3 < TWO_X) begin
         seg_in = 2'd1;
         xy     = x3 - ONE_X;
      end else begin
         seg_in = 2'd2;
         xy     = x3 - TWO_X;
      end
   end

   // stage B
   eap_pkg::tag_type tagb_ff;
   logic [FB-1:0]    pb_ff;
   logic [PB-1:0]    qb_ff;
   logic [PB-1:0]    q2b_ff;
   logic [FB-1:0]    yb_ff;
   logic [FB-2:0]    yyb_ff;
   logic [1:0]       segb_ff;
   logic [2*PB-1:0]  qq;
   logic [2*FB-1:0]  yy;

   assign qq = qa_ff * qa_ff;
   assign yy = ya_ff * ya_ff;

   // stage C
   eap_pkg::tag_type tagc_ff;
   logic [PB-1:0]    progc_ff;
   logic [2*PB-1:0]  qqq;
   logic [PB-1:0]    bounce;
   logic [PB-1:0]    curve;
   logic [PB-1:0]    prog_in;

   always_comb begin
      qqq = q2b_ff * qb_ff;
      case (segb_ff)
         2'd0:    bounce = {2'b00, yyb_ff};
         2'd1:    bounce = eap_pkg::HALF_Q + {1'b0, yb_ff} - {2'b00, yyb_ff};
         default: bounce = eap_pkg::ONE_Q - {2'b00, yyb_ff};
      endcase
      case (kind_i)
         eap_pkg::KIND_APPEAR: curve = '0;
         eap_pkg::KIND_CUBIC:  curve = eap_pkg::ONE_Q - qqq[2*FB:FB];
         eap_pkg::KIND_BOUNCE: curve = bounce;
         default:              curve = {1'b0, pb_ff};
      endcase
      case (tagb_ff.phase)
         eap_pkg::PH_WAIT: prog_in = '0;
         eap_pkg::PH_RUN:  prog_in = curve;
         default:          prog_in = eap_pkg::ONE_Q;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         taga_ff <= '0;
         tagb_ff <= '0;
         tagc_ff <= '0;
      end else if (adv) begin
         taga_ff <= tag_i;
         tagb_ff <= taga_ff;
         tagc_ff <= tagb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pa_ff    <= frac_i;
         qa_ff    <= eap_pkg::ONE_Q - {1'b0, frac_i};
         ya_ff    <= xy[FB-1:0];
         sega_ff  <= seg_in;
         pb_ff    <= pa_ff;
         qb_ff    <= qa_ff;
         q2b_ff   <= qq[2*FB:FB];
         yb_ff    <= ya_ff;
         yyb_ff   <= yy[2*FB-1:FB+1];
         segb_ff  <= sega_ff;
         progc_ff <= prog_in;
      end
   end

   assign tag_o  = tagc_ff;
   assign prog_o = progc_ff;

endmodule
`default_nettype wire

/* rtl/animation_eased_progress.sv */
// Eased animation progress.
// Request channel: req_time_now with req_valid/req_stall. Result channel:
// rsp_progress (Q1.16, 65536 = 1.0) and rsp_phase with rsp_valid/rsp_stall.
// Configuration: csr_wen, csr_index (0 start delay, 1 cycle length,
// 2 repeat enable, 3 ease kind), csr_wdata; write only while no item is in flight.
// Throughput: one item per cycle while rsp_stall does not hold the pipeline.
// An accepted item passes the delay subtract register, 32 stages of bit-serial
// remainder, 16 stages of fraction division, three for the ease curve and
// the output register before rsp_valid.
// Reset (synchronous, active high) empties the pipeline and clears all
// configuration to zero. While the result is held by rsp_stall the whole
// pipeline freezes and req_stall is raised; nothing is dropped or repeated.
`default_nettype none
module animation_eased_progress (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [eap_pkg::TIME_BITS-1:0] req_time_now,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [eap_pkg::PROG_BITS-1:0] rsp_progress,
   output logic      [1:0]                    rsp_phase,
   input  wire logic                          csr_wen,
   input  wire logic [1:0]                    csr_index,
   input  wire logic [31:0]                   csr_wdata
);
   localparam int TB = eap_pkg::TIME_BITS;
   localparam int PB = eap_pkg::PROG_BITS;

   logic [TB-1:0] delay_ff;
   logic [TB-1:0] dur_ff;
   logic          repeat_ff;
   logic [2:0]    kind_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff  <= '0;
         dur_ff    <= '0;
         repeat_ff <= 1'b0;
         kind_ff   <= '0;
      end else if (csr_wen) begin
         unique case (csr_index)
            eap_pkg::CSR_START_DELAY:   delay_ff  <= TB'(csr_wdata);
            eap_pkg::CSR_CYCLE_LENGTH:  dur_ff    <= TB'(csr_wdata);
            eap_pkg::CSR_REPEAT_ENABLE: repeat_ff <= csr_wdata[0];
            eap_pkg::CSR_EASE_KIND:     kind_ff   <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   logic          rsp_valid_ff;
   logic [PB-1:0] rsp_prog_ff;
   logic [1:0]    rsp_phase_ff;

   logic adv;
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // delay subtract and phase classification
   eap_pkg::tag_type tag0_ff;
   eap_pkg::tag_type tag0_in;
   logic [TB-1:0]    local0_ff;
   logic [TB-1:0]    local_in;

   always_comb begin
      local_in      = req_time_now - delay_ff;
      tag0_in.valid = req_valid;
      if (req_time_now < delay_ff) begin
         tag0_in.phase = eap_pkg::PH_WAIT;
      end else if (dur_ff == '0) begin
         tag0_in.phase = eap_pkg::PH_ZERO;
      end else if (!repeat_ff && local_in >= dur_ff) begin
         tag0_in.phase = eap_pkg::PH_HELD;
      end else begin
         tag0_in.phase = eap_pkg::PH_RUN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag0_ff <= '0;
      end else if (adv) begin
         tag0_ff <= tag0_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         local0_ff <= local_in;
      end
   end

   eap_pkg::tag_type             div_tag;
   logic [eap_pkg::FRAC_BITS-1:0] div_frac;

   eap_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .tag_i   (tag0_ff),
      .local_i (local0_ff),
      .dur_i   (dur_ff),
      .tag_o   (div_tag),
      .frac_o  (div_frac)
   );

   eap_pkg::tag_type ease_tag;
   logic [PB-1:0]    ease_prog;

   eap_ease u_ease (
      .clock  (clock),
      .reset  (reset),
      .adv    (adv),
      .kind_i (kind_ff),
      .tag_i  (div_tag),
      .frac_i (div_frac),
      .tag_o  (ease_tag),
      .prog_o (ease_prog)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= ease_tag.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_prog_ff  <= ease_prog;
         rsp_phase_ff <= ease_tag.phase;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_progress = rsp_prog_ff;
   assign rsp_phase    = rsp_phase_ff;

endmodule
`default_nettype wire

/* tb/animation_eased_progress_tb.sv */
`default_nettype none
module animation_eased_progress_tb;
   import eap_pkg::*;

   localparam int LATENCY   = 53;
   localparam int MAX_CYCLE = 400000;

   typedef struct {
      logic [PROG_BITS-1:0] progress;
      logic [1:0]           phase;
   } progress_result_type;

   class progress_board_type;
      logic [31:0]         start_delay;
      logic [31:0]         cycle_length;
      logic                repeat_enable;
      logic [2:0]          ease_kind;
      progress_result_type pending[$];
      int                  errors;
      int                  checked;

      function new();
         start_delay = '0;
         cycle_length = '0;
         repeat_enable = 1'b0;
         ease_kind = '0;
         errors = 0;
         checked = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [31:0] value);
         case (idx)
            CSR_START_DELAY: start_delay = value;
            CSR_CYCLE_LENGTH: cycle_length = value;
            CSR_REPEAT_ENABLE: repeat_enable = value[0];
            default: ease_kind = value[2:0];
         endcase
      endfunction

      function logic [63:0] ease(logic [63:0] p);
         logic [63:0] q, q2, q3, x, y;
         case (ease_kind)
            KIND_APPEAR: return 0;
            KIND_CUBIC: begin
               q = ONE_Q - p;
               q2 = (q * q) >> FRAC_BITS;
               q3 = (q2 * q) >> FRAC_BITS;
               return ONE_Q - q3;
            end
            KIND_BOUNCE: begin
               x = p * 3;
               if (x < ONE_Q) return (x * x) >> (FRAC_BITS + 1);
               if (x < 2 * ONE_Q) begin
                  y = x - ONE_Q;
                  return HALF_Q + y - ((y * y) >> (FRAC_BITS + 1));
               end
               y = x - 2 * ONE_Q;
               return ONE_Q - ((y * y) >> (FRAC_BITS + 1));
            end
            default: return p;
         endcase
      endfunction

      function void note_time(logic [31:0] t);
         progress_result_type r;
         logic [63:0] elapsed, frac;
         if (t < start_delay) begin
            r.progress = '0;
            r.phase = PH_WAIT;
         end else begin
            elapsed = t - start_delay;
            if (cycle_length == 0) begin
               r.progress = ONE_Q;
               r.phase = PH_ZERO;
            end else if (!repeat_enable && elapsed >= cycle_length) begin
               r.progress = ONE_Q;
               r.phase = PH_HELD;
            end else begin
               // fraction of the cycle, floor, Q0.16
               frac = ((elapsed % cycle_length) << FRAC_BITS) / cycle_length;
               r.progress = PROG_BITS'(ease(frac));
               r.phase = PH_RUN;
            end
         end
         pending.push_back(r);
      endfunction

      task report(string what);
         errors++;
         $display("mismatch: %s", what);
      endtask

      task check_result(logic [PROG_BITS-1:0] progress, logic [1:0] phase);
         progress_result_type e;
         if (pending.size() == 0) begin
            report($sformatf("unexpected item progress=%0d phase=%0d", progress, phase));
            return;
         end
         e = pending.pop_front();
         checked++;
         if (progress !== e.progress)
            report($sformatf("progress got %0d want %0d", progress, e.progress));
         if (phase !== e.phase)
            report($sformatf("phase got %0d want %0d", phase, e.phase));
      endtask
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [31:0]          req_time_now = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [PROG_BITS-1:0] rsp_progress;
   logic [1:0]           rsp_phase;
   logic                 csr_wen = 1'b0;
   logic [1:0]           csr_index = '0;
   logic [31:0]          csr_wdata = '0;

   progress_board_type   board = new();
   int                   send_idle = 0;
   int                   recv_idle = 0;
   int                   cycle = 0;
   int                   sent = 0;

   animation_eased_progress DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > MAX_CYCLE) begin
         $display("timeout");
         $display("FAILED: results differ");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_progress, rsp_phase);
      rsp_stall <= ($urandom_range(99) < recv_idle);
   end

   // leaves csr_wen high; configure drops it after the last write
   task automatic write_csr(logic [1:0] idx, logic [31:0] value);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      board.write_reg(idx, value);
      @(posedge clock);
   endtask

   task automatic send_time(logic [31:0] t);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_time_now <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_time(t);
      sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic configure(logic [31:0] dly, logic [31:0] len, logic rep, logic [2:0] kind);
      write_csr(CSR_START_DELAY, dly);
      write_csr(CSR_CYCLE_LENGTH, len);
      write_csr(CSR_REPEAT_ENABLE, {31'b0, rep});
      write_csr(CSR_EASE_KIND, {29'b0, kind});
      csr_wen <= 1'b0;
   endtask

   // mostly times around the delay and the first few cycles
   function automatic logic [31:0] pick_time();
      logic [31:0] dly, len;
      dly = board.start_delay;
      len = board.cycle_length;
      case ($urandom_range(5))
         0: return $urandom();
         1: return dly + $urandom_range(3) - 1;
         2: return dly + len + $urandom_range(3) - 1;
         default: return dly + ((len == 0) ? 32'($urandom_range(50)) :
                                32'(64'($urandom()) % (64'(len) * 3 + 1)));
      endcase
   endfunction

   function automatic logic [31:0] pick_len();
      case ($urandom_range(7))
         0: return 0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom();
         3: return $urandom_range(1, 8);
         default: return $urandom_range(1, 100000);
      endcase
   endfunction

   initial begin
      logic [31:0] dly;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // defaults after reset: zero duration straight away
      send_time(32'h0);
      send_time(32'hFFFF_FFFF);
      drain();
      for (int k = 0; k < 8; k++) begin
         configure(32'd100, 32'd300, k[0], k[2:0]);
         send_time(32'd99);
         send_time(32'd100);
         send_time(32'd200);
         send_time(32'd399);
         send_time(32'd400);
         send_time(32'd650);
         drain();
      end
      configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, KIND_CUBIC);
      send_time(32'hFFFF_FFFE);
      send_time(32'hFFFF_FFFF);
      drain();
      configure(32'h0, 32'hFFFF_FFFF, 1'b1, KIND_BOUNCE);
      send_time(32'hFFFF_FFFF);
      send_time(32'h5555_5555);
      send_time(32'hAAAA_AAAA);
      send_time(32'h0);
      drain();

      for (int phase_no = 0; phase_no < 3; phase_no++) begin
         send_idle = (phase_no == 0) ? 22 : (phase_no == 1) ? 84 : 0;
         recv_idle = (phase_no == 0) ? 84 : (phase_no == 1) ? 22 : 0;
         for (int s = 0; s < 20; s++) begin
            dly = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(0, 1000);
            configure(dly, pick_len(), 1'($urandom_range(1)), 3'($urandom_range(7)));
            for (int i = 0; i < 20; i++) begin
               send_time(pick_time());
               if (s == 3 && i == 10) begin
                  // hold off until the pipe is empty
                  req_valid <= 1'b0;
                  @(posedge clock);
                  while (board.pending.size() != 0) @(posedge clock);
               end
            end
            drain();
         end
      end
      recv_idle = 0;
      drain();

      $display("%0d time stamps sent, %0d results checked over many register settings",
               sent, board.checked);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end
endmodule
`default_nettype wire

/* files.f */
rtl/eap_pkg.sv
rtl/eap_divider.sv
rtl/eap_ease.sv
rtl/animation_eased_progress.sv
tb/animation_eased_progress_tb.sv
